// ----- rtl/sarl_pkg.sv -----
// ----------------------------------------------------------------------------
// sarl_pkg
// Shared types and codes of the sorted address range lookup.
// ----------------------------------------------------------------------------
package sarl_pkg;

    // operation codes
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    localparam int IDX_OUT_W = 10;
    localparam int FIELD_W   = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_PROBE,
        ST_CHECK,
        ST_BASE_RD,
        ST_BASE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [IDX_OUT_W-1:0] entry_index;
        logic [FIELD_W-1:0]   offset;
        logic [FIELD_W-1:0]   span;
    } result_t;

endpackage

// ----- rtl/sarl_ram.sv -----
// ----------------------------------------------------------------------------
// sarl_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module sarl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/sarl_engine.sv -----
// ----------------------------------------------------------------------------
// sarl_engine
// Table control: append, clear and the search sequencer over the start RAM.
// ----------------------------------------------------------------------------
module sarl_engine #(
    parameter int ENTRIES   = 1024,
    parameter int ADDR_BITS = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  logic [1:0]                 req_op,
    input  logic [ADDR_BITS-1:0]       req_addr,
    output logic                       res_valid,
    input  logic                       res_ready,
    output sarl_pkg::result_t          res,
    output logic                       ram_we,
    output logic [$clog2(ENTRIES)-1:0] ram_addr,
    output logic [ADDR_BITS-1:0]       ram_wdata,
    input  logic [ADDR_BITS-1:0]       ram_rdata
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    sarl_pkg::state_t  state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              sorted_reg, sorted_next;
    logic [ADDR_BITS-1:0] last_reg, last_next;
    logic [ADDR_BITS-1:0] query_reg, query_next;
    logic [ADDR_BITS-1:0] upper_reg, upper_next;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    sarl_pkg::result_t res_reg, res_next;

    logic [CNT_W:0]       mid_sum;
    logic [IDX_W-1:0]     mid;
    logic [CNT_W-1:0]     base_idx;
    logic [ADDR_BITS-1:0] offset_diff;
    logic [ADDR_BITS-1:0] span_diff;
    logic                 req_xfer;

    assign req_xfer = req_valid && req_ready;

    // halving step while the table is known ascending, single steps otherwise
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = sorted_reg ? mid_sum[IDX_W:1] : lo_reg[IDX_W-1:0];

    assign base_idx    = lo_reg - CNT_W'(1);
    assign offset_diff = query_reg - ram_rdata;
    assign span_diff   = upper_reg - ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sarl_pkg::ST_IDLE;
            count_reg  <= '0;
            sorted_reg <= 1'b1;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            sorted_reg <= sorted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg  <= last_next;
        query_reg <= query_next;
        upper_reg <= upper_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        res_reg   <= res_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        sorted_next = sorted_reg;
        last_next   = last_reg;
        query_next  = query_reg;
        upper_next  = upper_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        res_next    = res_reg;
        req_ready   = 1'b0;
        res_valid   = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = '0;
        ram_wdata   = req_addr;

        unique case (state_reg)
            sarl_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_xfer)
                begin
                    res_next   = '0;
                    query_next = req_addr;
                    state_next = sarl_pkg::ST_DONE;
                    unique case (req_op)
                        sarl_pkg::OP_APPEND:
                        begin
                            if (count_reg == CNT_W'(ENTRIES))
                            begin
                                res_next.status = sarl_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                ram_we   = 1'b1;
                                ram_addr = count_reg[IDX_W-1:0];
                                res_next.entry_index = sarl_pkg::IDX_OUT_W'(count_reg);
                                count_next = count_reg + CNT_W'(1);
                                last_next  = req_addr;
                                if ((count_reg != '0) && (req_addr < last_reg))
                                begin
                                    sorted_next = 1'b0;
                                end
                            end
                        end
                        sarl_pkg::OP_LOOKUP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = sarl_pkg::STATUS_NOT_FOUND;
                            end
                            else
                            begin
                                // read entry 0 for the below-first check
                                ram_addr   = '0;
                                state_next = sarl_pkg::ST_FIRST;
                            end
                        end
                        sarl_pkg::OP_CLEAR:
                        begin
                            count_next  = '0;
                            sorted_next = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            sarl_pkg::ST_FIRST:
            begin
                lo_next = CNT_W'(1);
                hi_next = count_reg;
                if ((query_reg < ram_rdata) || (count_reg == CNT_W'(1)))
                begin
                    res_next.status = sarl_pkg::STATUS_NOT_FOUND;
                    state_next      = sarl_pkg::ST_DONE;
                end
                else
                begin
                    state_next = sarl_pkg::ST_PROBE;
                end
            end
            sarl_pkg::ST_PROBE:
            begin
                ram_addr   = mid;
                state_next = sarl_pkg::ST_CHECK;
                // park the probe index in the result offset until the compare decides
                res_next.entry_index = sarl_pkg::IDX_OUT_W'(mid);
                res_next.offset      = sarl_pkg::FIELD_W'(mid);
            end
            sarl_pkg::ST_CHECK:
            begin
                // first entry above the query lies at or below the probe
                if (ram_rdata > query_reg)
                begin
                    hi_next    = CNT_W'(res_reg.offset);
                    upper_next = ram_rdata;
                end
                else
                begin
                    lo_next = CNT_W'(res_reg.offset) + CNT_W'(1);
                end
                if (lo_next == hi_next)
                begin
                    if (lo_next == count_reg)
                    begin
                        res_next        = '0;
                        res_next.status = sarl_pkg::STATUS_NOT_FOUND;
                        state_next      = sarl_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = sarl_pkg::ST_BASE_RD;
                    end
                end
                else
                begin
                    state_next = sarl_pkg::ST_PROBE;
                end
            end
            sarl_pkg::ST_BASE_RD:
            begin
                ram_addr   = base_idx[IDX_W-1:0];
                state_next = sarl_pkg::ST_BASE;
            end
            sarl_pkg::ST_BASE:
            begin
                res_next.status      = sarl_pkg::STATUS_OK;
                res_next.entry_index = sarl_pkg::IDX_OUT_W'(base_idx);
                res_next.offset      = sarl_pkg::FIELD_W'(offset_diff);
                res_next.span        = sarl_pkg::FIELD_W'(span_diff);
                state_next           = sarl_pkg::ST_DONE;
            end
            sarl_pkg::ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = sarl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sarl_pkg::ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

endmodule

// ----- rtl/sorted_address_range_lookup.sv -----
// ----------------------------------------------------------------------------
// sorted_address_range_lookup
// Maps a query address to the entry of an appended start table holding it.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  in        input      in_valid / in_ready    operation, address
//  out       output     out_valid / out_ready  status, entry_index, offset, span
//
//  append, clear and unused codes: the engine goes from idle straight to its result state.
//  lookup, ascending table: halving search over the entries,
//  one start RAM read per search step.
//  lookup after an out of order append: linear search, one entry per search step.
//  reset empties the table; no clearing pass is needed.
//  a result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module sorted_address_range_lookup #(
    parameter int ENTRIES   = 1024,
    parameter int ADDR_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [31:0] address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [9:0]  entry_index,
    output logic [31:0] offset,
    output logic [31:0] span
);

    localparam int IDX_W = $clog2(ENTRIES);

    logic [ADDR_BITS-1:0] req_addr;
    logic                 res_valid;
    logic                 res_ready;
    sarl_pkg::result_t    res;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_addr;
    logic [ADDR_BITS-1:0] ram_wdata;
    logic [ADDR_BITS-1:0] ram_rdata;

    logic                 out_valid_reg;
    sarl_pkg::result_t    out_reg;

    assign req_addr = ADDR_BITS'(address);

    sarl_engine #(
        .ENTRIES   (ENTRIES),
        .ADDR_BITS (ADDR_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (in_valid),
        .req_ready (in_ready),
        .req_op    (operation),
        .req_addr  (req_addr),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata)
    );

    sarl_ram #(
        .WIDTH (ADDR_BITS),
        .DEPTH (ENTRIES)
    ) u_start_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // output register frees the engine once a result is handed over
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_reg.status;
    assign entry_index = out_reg.entry_index;
    assign offset      = out_reg.offset;
    assign span        = out_reg.span;

endmodule
